// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL. Each macro expects signals named clk
// and rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define KRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define KRT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define KRT_ASSERT(label, prop, msg)
`define KRT_NEVER(label, cond, msg)

`endif

`endif

// ----- rtl/core/krt_pkg.sv -----
// ---------------------------------------------------------------------------
// krt_pkg
// Types, sizes and codes of the keyed record table.
// ---------------------------------------------------------------------------
package krt_pkg;

  // Number of records the table holds.
  localparam int CAPACITY = 64;

  // Index into the store, and a count that can reach CAPACITY.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef logic signed [31:0] key_t;
  typedef logic [63:0]        pay_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  // Operation codes carried in the func field.
  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_FIND   = 3'd1,
    FN_UPDATE = 3'd2,
    FN_REMOVE = 3'd3,
    FN_LIST   = 3'd4
  } func_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  // One stored record.
  typedef struct packed {
    key_t key;
    pay_t pay;
  } rec_t;

  // Write port of the record store.
  typedef struct packed {
    logic en;
    idx_t addr;
    rec_t data;
  } wr_req_t;

endpackage

// ----- rtl/core/krt_if.sv -----
// ---------------------------------------------------------------------------
// krt_if
// Valid/ready channels for request beats and result beats of the table.
// ---------------------------------------------------------------------------
interface krt_in_if;
  import krt_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] func;
  key_t       key;
  pay_t       payload;

  modport source (output valid, output func, output key, output payload, input ready);
  modport sink   (input valid, input func, input key, input payload, output ready);
endinterface

interface krt_out_if;
  import krt_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] status;
  key_t       rec_key;
  pay_t       rec_payload;
  logic       last;

  modport source (output valid, output status, output rec_key, output rec_payload,
                  output last, input ready);
  modport sink   (input valid, input status, input rec_key, input rec_payload,
                  input last, output ready);
endinterface

// ----- rtl/core/krt_store.sv -----
// ---------------------------------------------------------------------------
// krt_store
// Record memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module krt_store (
  input  logic             clk,
  input  krt_pkg::wr_req_t wr,
  input  krt_pkg::idx_t    rd_addr,
  output krt_pkg::rec_t    rd_data
);
  import krt_pkg::*;

  rec_t mem [CAPACITY];
  rec_t rd_data_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/keyed_record_table_top.sv -----
// ---------------------------------------------------------------------------
// keyed_record_table_top
// Packed table of keyed records with add, find, update, remove and list.
// ---------------------------------------------------------------------------
// Usage: request beats arrive on in_ch (func, key, payload); result beats
// leave on out_ch (status, rec_key, rec_payload, last). in_ch.ready is high
// only while the sequencer is idle; one request is worked at a time.
// A request is first decoded, then walks the store one entry per cycle
// through the single registered read port, unless a due beat is held up:
//   add             scans for a duplicate key, then appends
//   find, update    scan up to the key, or to the last entry when absent
//   remove          as find, then moves each later record down
//   list            walks every entry, one result beat per record
// Errors (full, empty) finish in the decode cycle. Unknown codes give no beat.
// Results land in an output register, so a new request is taken while the
// last beat still waits. When out_ch.ready is low and a further beat is due,
// the sequencer holds its place until the output register frees.
// Reset clears the entry count and the sequencer; the store itself is never
// cleared, since only entries below the count are read. No clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module keyed_record_table_top (
  input  logic      clk,
  input  logic      rst_n,
  krt_in_if.sink    in_ch,
  krt_out_if.source out_ch
);
  import krt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_LIST
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] func_r, func_nxt;
  key_t       key_r, key_nxt;
  pay_t       pay_r, pay_nxt;
  idx_t       idx_r, idx_nxt;
  cnt_t       count_r, count_nxt;

  logic       ovalid_r, ovalid_nxt;
  status_t    ostatus_r, ostatus_nxt;
  key_t       okey_r, okey_nxt;
  pay_t       opay_r, opay_nxt;
  logic       olast_r, olast_nxt;

  wr_req_t    wr;
  idx_t       rd_addr;
  rec_t       rdata;

  logic       out_free;
  logic       emit;
  status_t    e_status;
  key_t       e_key;
  pay_t       e_pay;
  logic       e_last;
  logic       hit;
  logic       at_end;
  logic [CNT_W:0] idx1, idx2, cnt_x;

  krt_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  // Positions one and two past the current entry, against the count.
  assign idx1   = {1'b0, CNT_W'(idx_r)} + (CNT_W+1)'(1);
  assign idx2   = {1'b0, CNT_W'(idx_r)} + (CNT_W+1)'(2);
  assign cnt_x  = {1'b0, count_r};
  assign hit    = (rdata.key == key_r);
  assign at_end = (idx1 == cnt_x);

  // The output register can take a beat when empty or being drained.
  assign out_free = !ovalid_r || out_ch.ready;

  // Sequencer: decode, scan, shift and list over the shared read port.
  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    rd_addr   = idx_r;
    wr        = '0;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_key     = '0;
    e_pay     = '0;
    e_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt  = in_ch.func;
          key_nxt   = in_ch.key;
          pay_nxt   = in_ch.payload;
          state_nxt = S_START;
        end
      end

      S_START: begin
        idx_nxt = '0;
        rd_addr = '0;
        case (func_r)
          FN_ADD: begin
            if (count_r == CNT_W'(CAPACITY)) begin
              if (out_free) begin
                emit      = 1'b1;
                e_status  = ST_FULL;
                state_nxt = S_IDLE;
              end
            end else if (count_r == '0) begin
              if (out_free) begin
                wr.en     = 1'b1;
                wr.addr   = '0;
                wr.data   = '{key: key_r, pay: pay_r};
                count_nxt = count_r + CNT_W'(1);
                emit      = 1'b1;
                e_key     = key_r;
                e_pay     = pay_r;
                state_nxt = S_IDLE;
              end
            end else begin
              state_nxt = S_SCAN;
            end
          end
          FN_FIND, FN_UPDATE, FN_REMOVE, FN_LIST: begin
            if (count_r == '0) begin
              if (out_free) begin
                emit      = 1'b1;
                e_status  = ST_EMPTY;
                state_nxt = S_IDLE;
              end
            end else if (func_r == FN_LIST) begin
              state_nxt = S_LIST;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        if (hit || at_end) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
            if (func_r == FN_ADD) begin
              if (hit) begin
                e_status = ST_DUP;
              end else begin
                wr.en     = 1'b1;
                wr.addr   = count_r[IDX_W-1:0];
                wr.data   = '{key: key_r, pay: pay_r};
                count_nxt = count_r + CNT_W'(1);
                e_key     = key_r;
                e_pay     = pay_r;
              end
            end else if (!hit) begin
              e_status = ST_MISSING;
            end else begin
              e_key = rdata.key;
              e_pay = rdata.pay;
              if (func_r == FN_UPDATE) begin
                wr.en   = 1'b1;
                wr.addr = idx_r;
                wr.data = '{key: rdata.key, pay: pay_r};
                e_pay   = pay_r;
              end else if (func_r == FN_REMOVE) begin
                if (idx1 < cnt_x) begin
                  rd_addr   = idx1[IDX_W-1:0];
                  state_nxt = S_SHIFT;
                end else begin
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
          end
        end else begin
          idx_nxt = idx1[IDX_W-1:0];
          rd_addr = idx1[IDX_W-1:0];
        end
      end

      // Here rdata holds the record one above idx_r; move it down.
      S_SHIFT: begin
        wr.en   = 1'b1;
        wr.addr = idx_r;
        wr.data = rdata;
        if (idx2 < cnt_x) begin
          idx_nxt = idx1[IDX_W-1:0];
          rd_addr = idx2[IDX_W-1:0];
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_IDLE;
        end
      end

      S_LIST: begin
        if (out_free) begin
          emit   = 1'b1;
          e_key  = rdata.key;
          e_pay  = rdata.pay;
          e_last = at_end;
          if (at_end) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx1[IDX_W-1:0];
            rd_addr = idx1[IDX_W-1:0];
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loaded on a new result, emptied when the beat is taken.
  always_comb begin
    ovalid_nxt  = ovalid_r;
    ostatus_nxt = ostatus_r;
    okey_nxt    = okey_r;
    opay_nxt    = opay_r;
    olast_nxt   = olast_r;
    if (emit) begin
      ovalid_nxt  = 1'b1;
      ostatus_nxt = e_status;
      okey_nxt    = e_key;
      opay_nxt    = e_pay;
      olast_nxt   = e_last;
    end else if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
    end
    func_r    <= func_nxt;
    key_r     <= key_nxt;
    pay_r     <= pay_nxt;
    ostatus_r <= ostatus_nxt;
    okey_r    <= okey_nxt;
    opay_r    <= opay_nxt;
    olast_r   <= olast_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = ovalid_r;
  assign out_ch.status      = ostatus_r;
  assign out_ch.rec_key     = okey_r;
  assign out_ch.rec_payload = opay_r;
  assign out_ch.last        = olast_r;

  // The entry count never passes the capacity.
  `KRT_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  // Stores only touch live entries or the first free slot.
  `KRT_ASSERT(a_wr_in_range, wr.en |-> (CNT_W'(wr.addr) <= count_r), "write past the fill")
  // A new result never overwrites a beat that is still waiting.
  `KRT_NEVER(a_no_overrun, emit && ovalid_r && !out_ch.ready, "result register overrun")

endmodule
